FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
// Depends on nothing; users provide i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cosim_pkg.sv
// Package for the cosine similarity scorer: sizes, beat structs, sequencer states.
// No dependencies.
package cosim_pkg;

    localparam int MAX_TERMS = 64;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int LOG_T     = $clog2(MAX_TERMS);

    localparam int DOC_W     = 20;
    localparam int QW_W      = 8;
    localparam int DW_W      = 16;
    localparam int SCORE_W   = 16;
    localparam int FRAC      = 15;

    localparam int DOT_W     = QW_W + DW_W + LOG_T;
    localparam int QN_W      = 2 * QW_W + LOG_T;
    localparam int DN_W      = 2 * DW_W + LOG_T;

    localparam int MUL_W     = DOT_W;
    localparam int PRD_W     = 2 * MUL_W;
    localparam int DN_H      = (DN_W + 1) / 2;

    localparam int P_W       = QN_W + DN_W;
    localparam int CW        = P_W + 2 * FRAC + 3;
    localparam int K_W       = $clog2(SCORE_W);

    localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1) << FRAC;

    typedef struct packed {
        logic [DOC_W-1:0] doc_id;
        logic [QW_W-1:0]  query_weight;
        logic [DW_W-1:0]  doc_weight;
        logic             last_term;
    } t_in;

    typedef struct packed {
        logic [DOC_W-1:0]   result_doc;
        logic [SCORE_W-1:0] score;
        logic               zero_denominator;
        logic               term_overflow;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_DOT,
        ST_T_QN,
        ST_T_DN,
        ST_T_ACC,
        ST_F_P0,
        ST_F_P1,
        ST_F_R,
        ST_F_INIT,
        ST_SQ_A,
        ST_SQ_B
    } t_state;

endpackage

FILE: rtl/cosine_similarity_scorer.sv
// Cosine similarity scorer: one shared multiplier plus a bitwise score search.
// Depends on cosim_pkg and assert_macros.svh.
//
// Terms arrive one beat at a time (start while busy is low). Each accepted term
// keeps the block busy through states T_DOT, T_QN, T_DN and T_ACC, as the
// single multiplier forms the three products of a term one after another; a
// new term is taken only back in idle. A term beyond MAX_TERMS is only flagged
// and not accumulated. On the last term the block forms qnorm*dnorm (two partial
// products) and dot*dot on the same multiplier, then finds the score one bit
// per pass through states SQ_A and SQ_B over 16 bits; the result beat comes
// after the final SQ_B step, or after F_P0 when a norm is zero. o_strobe
// marks a result for exactly one cycle; the receiver cannot hold it off, so it
// must take every result beat as it comes.
`include "assert_macros.svh"

module cosine_similarity_scorer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cosim_pkg::t_in    i_item,
    output logic              o_strobe,
    output cosim_pkg::t_out   o_result
);
    import cosim_pkg::*;

    t_state             r_state, n_state;
    logic               r_strobe, n_strobe;
    logic [DOT_W-1:0]   r_dot, n_dot;
    logic [QN_W-1:0]    r_qn, n_qn;
    logic [DN_W-1:0]    r_dn, n_dn;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;

    t_in                r_item, n_item;
    t_out               r_out, n_out;
    logic [PRD_W-1:0]   r_prod, n_prod;
    logic [CW-1:0]      r_pk, n_pk;
    logic [CW-1:0]      r_tk, n_tk;
    logic [CW-1:0]      r_inc, n_inc;
    logic [CW-1:0]      r_rem, n_rem;
    logic [SCORE_W-1:0] r_s, n_s;
    logic [K_W-1:0]     r_k, n_k;

    logic [MUL_W-1:0]   mul_a, mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_dot    <= '0;
            r_qn     <= '0;
            r_dn     <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_dot    <= n_dot;
            r_qn     <= n_qn;
            r_dn     <= n_dn;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
        r_prod <= n_prod;
        r_pk   <= n_pk;
        r_tk   <= n_tk;
        r_inc  <= n_inc;
        r_rem  <= n_rem;
        r_s    <= n_s;
        r_k    <= n_k;
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_T_DOT: begin
                mul_a = MUL_W'(r_item.query_weight);
                mul_b = MUL_W'(r_item.doc_weight);
            end
            ST_T_QN: begin
                mul_a = MUL_W'(r_item.query_weight);
                mul_b = MUL_W'(r_item.query_weight);
            end
            ST_T_DN: begin
                mul_a = MUL_W'(r_item.doc_weight);
                mul_b = MUL_W'(r_item.doc_weight);
            end
            ST_F_P0: begin
                mul_a = MUL_W'(r_qn);
                mul_b = MUL_W'(r_dn[DN_H-1:0]);
            end
            ST_F_P1: begin
                mul_a = MUL_W'(r_qn);
                mul_b = MUL_W'(r_dn[DN_W-1:DN_H]);
            end
            ST_F_R: begin
                mul_a = MUL_W'(r_dot);
                mul_b = MUL_W'(r_dot);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = PRD_W'(mul_a) * PRD_W'(mul_b);
    end

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_dot    = r_dot;
        n_qn     = r_qn;
        n_dn     = r_dn;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_item   = r_item;
        n_out    = r_out;
        n_pk     = r_pk;
        n_tk     = r_tk;
        n_inc    = r_inc;
        n_rem    = r_rem;
        n_s      = r_s;
        n_k      = r_k;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    if (r_count == CNT_W'(MAX_TERMS)) begin
                        n_ovf   = 1'b1;
                        n_state = i_item.last_term ? ST_F_P0 : ST_IDLE;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                        n_state = ST_T_DOT;
                    end
                end
            end
            ST_T_DOT: begin
                n_state = ST_T_QN;
            end
            ST_T_QN: begin
                n_dot   = r_dot + r_prod[DOT_W-1:0];
                n_state = ST_T_DN;
            end
            ST_T_DN: begin
                n_qn    = r_qn + r_prod[QN_W-1:0];
                n_state = ST_T_ACC;
            end
            ST_T_ACC: begin
                n_dn    = r_dn + r_prod[DN_W-1:0];
                n_state = r_item.last_term ? ST_F_P0 : ST_IDLE;
            end
            ST_F_P0: begin
                if (r_qn == '0 || r_dn == '0) begin
                    n_out.result_doc       = r_item.doc_id;
                    n_out.score            = '0;
                    n_out.zero_denominator = 1'b1;
                    n_out.term_overflow    = r_ovf;
                    n_strobe = 1'b1;
                    n_dot    = '0;
                    n_qn     = '0;
                    n_dn     = '0;
                    n_count  = '0;
                    n_ovf    = 1'b0;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_F_P1;
                end
            end
            ST_F_P1: begin
                n_pk    = CW'(r_prod);
                n_state = ST_F_R;
            end
            ST_F_R: begin
                n_pk    = r_pk + (CW'(r_prod) << DN_H);
                n_state = ST_F_INIT;
            end
            ST_F_INIT: begin
                n_rem   = CW'(r_prod) << (2 * FRAC);
                n_pk    = r_pk << (2 * (SCORE_W - 1));
                n_tk    = '0;
                n_s     = '0;
                n_k     = K_W'(SCORE_W - 1);
                n_state = ST_SQ_A;
            end
            ST_SQ_A: begin
                n_inc   = r_tk + r_pk;
                n_state = ST_SQ_B;
            end
            ST_SQ_B: begin
                if (r_inc <= r_rem) begin
                    n_rem      = r_rem - r_inc;
                    n_tk       = (r_inc + r_pk) >> 1;
                    n_s[r_k]   = 1'b1;
                end else begin
                    n_tk = r_tk >> 1;
                end
                n_pk = r_pk >> 2;
                if (r_k == '0) begin
                    n_out.result_doc       = r_item.doc_id;
                    n_out.score            = n_s;
                    n_out.zero_denominator = 1'b0;
                    n_out.term_overflow    = r_ovf;
                    n_strobe = 1'b1;
                    n_dot    = '0;
                    n_qn     = '0;
                    n_dn     = '0;
                    n_count  = '0;
                    n_ovf    = 1'b0;
                    n_state  = ST_IDLE;
                end else begin
                    n_k     = r_k - K_W'(1);
                    n_state = ST_SQ_A;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    `ASSERT_IMPLIES(a_strobe_ends_work, o_strobe, $past(busy) && !busy, "result beat without work")
    `ASSERT_IMPLIES(a_zero_den_score, o_strobe && o_result.zero_denominator, o_result.score == '0, "zero denominator with nonzero score")
    `ASSERT_IMPLIES(a_score_range, o_strobe, o_result.score <= SCORE_ONE, "score above one")
    `ASSERT_IMPLIES(a_result_clears, o_strobe, r_count == '0 && !r_ovf, "state not cleared after result")

endmodule

FILE: tb/cosine_similarity_scorer_tb.sv
// Self-checking testbench for cosine_similarity_scorer: directed and random term beats
// scored by a behavioral predictor held in a scoreboard class. Depends on cosim_pkg.
`timescale 1ns / 1ps

module cosine_similarity_scorer_tb;
    import cosim_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TERM_TARGET  = 700;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int SETTLE       = 40;

    class doc_score_predictor;
        t_out        pending_scores[$];
        logic [63:0] dot_acc     = '0;
        logic [63:0] qnorm_acc   = '0;
        logic [63:0] dnorm_acc   = '0;
        int unsigned terms_held  = 0;
        bit          overflow_flag = 1'b0;
        int          errors        = 0;
        int          docs_scored   = 0;
        int          overflow_docs = 0;
        int          zero_docs     = 0;

        // largest s in 0..32768 with s*s*qn*dn <= dot*dot*2^30
        function logic [SCORE_W-1:0] cosine_q15(logic [63:0] dot, logic [63:0] qn,
                                                logic [63:0] dn);
            logic [127:0] bound;
            logic [127:0] prod;
            logic [127:0] s;
            logic [16:0]  lo;
            logic [16:0]  hi;
            logic [16:0]  mid;
            bound = ({64'd0, dot} * {64'd0, dot}) << 30;
            lo = '0;
            hi = 17'd32768;
            while (lo < hi) begin
                mid  = (lo + hi + 17'd1) >> 1;
                s    = {111'd0, mid};
                prod = s * s * {64'd0, qn} * {64'd0, dn};
                if (prod <= bound) begin
                    lo = mid;
                end else begin
                    hi = mid - 17'd1;
                end
            end
            return lo[SCORE_W-1:0];
        endfunction

        function void note_term(t_in term);
            t_out res;
            if (terms_held >= MAX_TERMS) begin
                overflow_flag = 1'b1;
            end else begin
                dot_acc   += term.query_weight * term.doc_weight;
                qnorm_acc += term.query_weight * term.query_weight;
                dnorm_acc += term.doc_weight * term.doc_weight;
                terms_held++;
            end
            if (!term.last_term) return;
            res.result_doc = term.doc_id;
            if (qnorm_acc == 0 || dnorm_acc == 0) begin
                res.score            = '0;
                res.zero_denominator = 1'b1;
                zero_docs++;
            end else begin
                res.score            = cosine_q15(dot_acc, qnorm_acc, dnorm_acc);
                res.zero_denominator = 1'b0;
            end
            res.term_overflow = overflow_flag;
            if (overflow_flag) overflow_docs++;
            docs_scored++;
            pending_scores = {pending_scores, res};
            dot_acc       = '0;
            qnorm_acc     = '0;
            dnorm_acc     = '0;
            terms_held    = 0;
            overflow_flag = 1'b0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_score(t_out got);
            t_out want;
            if (pending_scores.size() == 0) begin
                report($sformatf("unexpected result beat, doc %05h", got.result_doc));
                return;
            end
            want = pending_scores.pop_front();
            if (got.result_doc !== want.result_doc)
                report($sformatf("result_doc %05h, want %05h", got.result_doc,
                                 want.result_doc));
            if (got.score !== want.score)
                report($sformatf("doc %05h score %0d, want %0d", want.result_doc,
                                 got.score, want.score));
            if (got.zero_denominator !== want.zero_denominator)
                report($sformatf("doc %05h zero_denominator %b, want %b", want.result_doc,
                                 got.zero_denominator, want.zero_denominator));
            if (got.term_overflow !== want.term_overflow)
                report($sformatf("doc %05h term_overflow %b, want %b", want.result_doc,
                                 got.term_overflow, want.term_overflow));
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_in  i_item  = '0;
    logic o_strobe;
    t_out o_result;

    doc_score_predictor scorer = new;
    int sent_terms = 0;
    int cycles     = 0;

    cosine_similarity_scorer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     scorer.pending_scores.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result beats cannot be held off: take each one as it comes
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) scorer.check_score(o_result);
    end

    task automatic send_term(input t_in term);
        bit steady;
        steady = (sent_terms >= 250 && sent_terms < 420);
        if (!steady && $urandom_range(99) < 32) begin
            start <= 1'b0;
            // idle cycles count only while the block could take a beat
            repeat ($urandom_range(1, 4)) begin
                do @(posedge i_clk); while (busy);
            end
        end
        i_item <= term;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        scorer.note_term(term);
        sent_terms++;
    endtask

    task automatic term(input logic [DOC_W-1:0] doc, input logic [QW_W-1:0] qw,
                        input logic [DW_W-1:0] dw, input logic last);
        t_in t;
        t.doc_id       = doc;
        t.query_weight = qw;
        t.doc_weight   = dw;
        t.last_term    = last;
        send_term(t);
    endtask

    function automatic logic [QW_W-1:0] pick_query_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return QW_W'($urandom_range(255, 1));
        endcase
    endfunction

    function automatic logic [DW_W-1:0] pick_doc_weight(bit sparse);
        int roll;
        roll = $urandom_range(99);
        if (sparse || roll < 20) return '0;
        if (roll < 25) return '1;
        return DW_W'($urandom());
    endfunction

    initial begin
        int          n_terms;
        int          pick;
        int          w;
        bit          sparse;
        bit          mixed_ids;
        logic [DOC_W-1:0] doc;
        t_in         t;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: full match, zero norms, orthogonal, extremes, mixed doc ids
        term(20'hFFFFF, 8'd255, 16'hFFFF, 1'b1);
        term(20'h00000, 8'd0,   16'h0000, 1'b1);
        term(20'h00001, 8'd0,   16'd1234, 1'b1);
        term(20'h00002, 8'd200, 16'h0000, 1'b1);
        term(20'h00003, 8'd1,   16'h0000, 1'b0);
        term(20'h00003, 8'd0,   16'h0001, 1'b1);
        term(20'h00004, 8'd255, 16'h0001, 1'b0);
        term(20'h00004, 8'd1,   16'hFFFF, 1'b1);
        term(20'h00005, 8'd17,  16'h1000, 1'b0);
        term(20'h5A5A5, 8'd3,   16'd12345, 1'b0);
        term(20'hA5A5A, 8'd255, 16'hFFFF, 1'b1);
        term(20'h00006, 8'd128, 16'h8000, 1'b0);
        term(20'h00006, 8'd127, 16'h7FFF, 1'b1);

        while (sent_terms < TERM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 70)      n_terms = $urandom_range(8, 1);
            else if (pick < 85) n_terms = $urandom_range(40, 9);
            else if (pick < 93) n_terms = MAX_TERMS - 1 + $urandom_range(2);
            else                n_terms = $urandom_range(MAX_TERMS + 16, MAX_TERMS + 2);
            sparse    = ($urandom_range(19) == 0);
            mixed_ids = ($urandom_range(9) == 0);
            doc       = DOC_W'($urandom());
            for (int k = 0; k < n_terms; k++) begin
                t.doc_id       = mixed_ids ? DOC_W'($urandom()) : doc;
                t.query_weight = pick_query_weight();
                t.doc_weight   = pick_doc_weight(sparse);
                t.last_term    = (k == n_terms - 1);
                send_term(t);
            end
        end
        start <= 1'b0;

        for (w = 0; w < DRAIN_LIMIT && scorer.pending_scores.size() != 0; w++)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        while (scorer.pending_scores.size() != 0) begin
            t_out lost;
            lost = scorer.pending_scores.pop_front();
            scorer.report($sformatf("no result beat for doc %05h", lost.result_doc));
        end

        $display("scored %0d documents from %0d term beats (%0d overflowed, %0d zero norm)",
                 scorer.docs_scored, sent_terms, scorer.overflow_docs, scorer.zero_docs);
        $display("%0d mismatches in %0d cycles", scorer.errors, cycles);
        if (scorer.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
